FILE: sv/assert_macros.svh
// Assertion macros shared by the transform core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: sv/mvt_pkg.sv
// Shared types, widths and helpers of the matrix vector transform core.
package mvt_pkg;

   // Number format and matrix shape
   localparam int FRAC_BITS  = 16;
   localparam int WORD_BITS  = 32;
   localparam int FIELD_BITS = 32;
   localparam int DIM        = 4;
   localparam int ENTRIES    = DIM * DIM;
   localparam int INDEX_BITS = $clog2(ENTRIES);

   // Datapath growth: product, pair sum, row sum, shifted row sum
   localparam int PROD_BITS  = 2 * WORD_BITS;
   localparam int PAIR_BITS  = PROD_BITS + 1;
   localparam int SUM_BITS   = PROD_BITS + 2;
   localparam int SHIFT_BITS = SUM_BITS - FRAC_BITS;

   typedef enum logic {
      KIND_LOAD  = 1'b0,
      KIND_XFORM = 1'b1
   } kind_type;

   typedef logic        [FIELD_BITS-1:0] field_type;
   typedef logic signed [WORD_BITS-1:0]  word_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [PAIR_BITS-1:0]  pair_type;
   typedef logic signed [SUM_BITS-1:0]   sum_type;
   typedef logic signed [SHIFT_BITS-1:0] shift_type;

   typedef field_type [DIM-1:0]       vec_field_type;
   typedef prod_type  [ENTRIES-1:0]   prod_array_type;
   typedef pair_type  [2*DIM-1:0]     pair_array_type;
   typedef sum_type   [DIM-1:0]       sum_array_type;

   // Identity diagonal value, low word bits of one
   localparam word_type ONE_WORD = word_type'(64'd1 << FRAC_BITS);

   // Take a field as a signed word: sign-extend or keep the low bits
   function automatic word_type to_word(field_type f);
      return word_type'($signed(f));
   endfunction

   // Give a word as an output field, zero-extended or truncated
   function automatic field_type to_field(word_type w);
      return field_type'($unsigned(w));
   endfunction

endpackage

FILE: sv/mvt_mul_stage.sv
// Matrix store and first pipeline stage: sixteen registered products.
`include "assert_macros.svh"

module mvt_mul_stage (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  mvt_pkg::kind_type               in_kind,
   input  logic [mvt_pkg::INDEX_BITS-1:0]  entry_index,
   input  mvt_pkg::field_type              entry_value,
   input  mvt_pkg::vec_field_type          vec,
   output logic                            out_valid,
   input  logic                            out_ready,
   output mvt_pkg::prod_array_type         out_prod
);

   mvt_pkg::word_type       matrix_ff [mvt_pkg::ENTRIES];
   mvt_pkg::prod_array_type prod_ff;
   mvt_pkg::prod_array_type prod_in;
   logic                    valid_ff;
   logic                    valid_in;
   logic                    accept;
   logic                    advance;

   // Stage takes a request when empty or when its contents move on
   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;
   assign advance  = accept && (in_kind == mvt_pkg::KIND_XFORM);

   always_comb begin
      valid_in = valid_ff;
      if (out_ready) begin
         valid_in = 1'b0;
      end
      if (advance) begin
         valid_in = 1'b1;
      end
   end

   // One product per matrix entry against the matching vector component
   always_comb begin
      for (int r = 0; r < mvt_pkg::DIM; r++) begin
         for (int c = 0; c < mvt_pkg::DIM; c++) begin
            prod_in[r*mvt_pkg::DIM+c] = matrix_ff[r*mvt_pkg::DIM+c]
                                       * mvt_pkg::to_word(vec[c]);
         end
      end
   end

   // Matrix store: identity after reset, one entry written per load request
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < mvt_pkg::DIM; r++) begin
            for (int c = 0; c < mvt_pkg::DIM; c++) begin
               matrix_ff[r*mvt_pkg::DIM+c] <= (r == c) ? mvt_pkg::ONE_WORD : '0;
            end
         end
      end else if (accept && (in_kind == mvt_pkg::KIND_LOAD)) begin
         matrix_ff[entry_index] <= mvt_pkg::to_word(entry_value);
      end
   end

   // Stage valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Product registers, loaded only by transform requests
   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_prod  = prod_ff;

   `ASSERT_IMPLY(mul_ready_when_empty, clock, reset, !valid_ff, in_ready)
   `ASSERT_NEXT(mul_load_no_item, clock, reset,
      accept && (in_kind == mvt_pkg::KIND_LOAD) && (!valid_ff || out_ready), !valid_ff)

endmodule

FILE: sv/mvt_add_stage.sv
// Second and third pipeline stages: pair sums, then row sums.
`include "assert_macros.svh"

module mvt_add_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  mvt_pkg::prod_array_type  in_prod,
   output logic                     out_valid,
   input  logic                     out_ready,
   output mvt_pkg::sum_array_type   out_sum
);

   mvt_pkg::pair_array_type pair_ff;
   mvt_pkg::pair_array_type pair_in;
   mvt_pkg::sum_array_type  row_ff;
   mvt_pkg::sum_array_type  row_in;
   logic                    pair_valid_ff;
   logic                    row_valid_ff;
   logic                    row_ready;
   logic                    pair_load;
   logic                    row_load;

   // Backward ready through both levels
   assign row_ready = !row_valid_ff || out_ready;
   assign in_ready  = !pair_valid_ff || row_ready;
   assign pair_load = in_valid && in_ready;
   assign row_load  = pair_valid_ff && row_ready;

   // Add neighbouring products of each row
   always_comb begin
      for (int p = 0; p < 2 * mvt_pkg::DIM; p++) begin
         pair_in[p] = mvt_pkg::PAIR_BITS'($signed(in_prod[2*p]))
                    + mvt_pkg::PAIR_BITS'($signed(in_prod[2*p+1]));
      end
   end

   // Add the two pair sums of each row
   always_comb begin
      for (int r = 0; r < mvt_pkg::DIM; r++) begin
         row_in[r] = mvt_pkg::SUM_BITS'($signed(pair_ff[2*r]))
                   + mvt_pkg::SUM_BITS'($signed(pair_ff[2*r+1]));
      end
   end

   // Valid bits of both levels
   always_ff @(posedge clock) begin
      if (reset) begin
         pair_valid_ff <= 1'b0;
         row_valid_ff  <= 1'b0;
      end else begin
         if (pair_load) begin
            pair_valid_ff <= 1'b1;
         end else if (row_ready) begin
            pair_valid_ff <= 1'b0;
         end
         if (row_load) begin
            row_valid_ff <= 1'b1;
         end else if (out_ready) begin
            row_valid_ff <= 1'b0;
         end
      end
   end

   // Data registers, held while stalled
   always_ff @(posedge clock) begin
      if (pair_load) begin
         pair_ff <= pair_in;
      end
      if (row_load) begin
         row_ff <= row_in;
      end
   end

   assign out_valid = row_valid_ff;
   assign out_sum   = row_ff;

   `ASSERT_NEXT(add_row_held, clock, reset, row_valid_ff && !out_ready, row_valid_ff)

endmodule

FILE: sv/mvt_sat_stage.sv
// Last pipeline stage: shift, saturate and hold the result register.
`include "assert_macros.svh"

module mvt_sat_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  mvt_pkg::sum_array_type  in_sum,
   output logic                    out_valid,
   input  logic                    out_ready,
   output mvt_pkg::vec_field_type  out_words,
   output logic                    out_saturated
);

   localparam mvt_pkg::word_type WORD_MAX = {1'b0, {(mvt_pkg::WORD_BITS-1){1'b1}}};
   localparam mvt_pkg::word_type WORD_MIN = {1'b1, {(mvt_pkg::WORD_BITS-1){1'b0}}};

   mvt_pkg::vec_field_type words_ff;
   mvt_pkg::vec_field_type words_in;
   logic                   sat_ff;
   logic                   sat_in;
   logic                   valid_ff;
   logic                   load;
   mvt_pkg::shift_type     shifted [mvt_pkg::DIM];
   logic [mvt_pkg::DIM-1:0] clip;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   // Drop the fraction bits, then clip to the word range
   always_comb begin
      for (int r = 0; r < mvt_pkg::DIM; r++) begin
         shifted[r] = mvt_pkg::SHIFT_BITS'(in_sum[r] >>> mvt_pkg::FRAC_BITS);
         clip[r] = !((&shifted[r][mvt_pkg::SHIFT_BITS-1:mvt_pkg::WORD_BITS-1])
                  || !(|shifted[r][mvt_pkg::SHIFT_BITS-1:mvt_pkg::WORD_BITS-1]));
         if (!clip[r]) begin
            words_in[r] = mvt_pkg::to_field(mvt_pkg::WORD_BITS'(shifted[r]));
         end else if (shifted[r][mvt_pkg::SHIFT_BITS-1]) begin
            words_in[r] = mvt_pkg::to_field(WORD_MIN);
         end else begin
            words_in[r] = mvt_pkg::to_field(WORD_MAX);
         end
      end
      sat_in = |clip;
   end

   // Result valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   // Result register, held while the receiver stalls
   always_ff @(posedge clock) begin
      if (load) begin
         words_ff <= words_in;
         sat_ff   <= sat_in;
      end
   end

   assign out_valid     = valid_ff;
   assign out_words     = words_ff;
   assign out_saturated = sat_ff;

   `ASSERT_IMPLY(sat_flag_at_limit, clock, reset, valid_ff && sat_ff,
      (words_ff[0] == mvt_pkg::to_field(WORD_MAX)) || (words_ff[0] == mvt_pkg::to_field(WORD_MIN))
      || (words_ff[1] == mvt_pkg::to_field(WORD_MAX)) || (words_ff[1] == mvt_pkg::to_field(WORD_MIN))
      || (words_ff[2] == mvt_pkg::to_field(WORD_MAX)) || (words_ff[2] == mvt_pkg::to_field(WORD_MIN))
      || (words_ff[3] == mvt_pkg::to_field(WORD_MAX)) || (words_ff[3] == mvt_pkg::to_field(WORD_MIN)))

endmodule

FILE: sv/matrix_vector_transform_core.sv
// Top level of the 4x4 matrix by vector transform core.
//
// Requests arrive on the req_ stream. tuser bit 0 selects the kind: a load
// request (0) writes one entry of the stored 4x4 matrix and gives no result;
// a transform request (1) multiplies the stored matrix by the vector in
// tdata. Each result on the rsp_ stream holds the four row dot products,
// shifted down by the fraction bits and clipped to a signed word, and a
// saturation flag in tuser bit 0.
//
// Throughput is one request per clock while rsp_tready stays high. A transform
// result passes four register stages: the sixteen products, the pair sums,
// the row sums and the shifted and clipped result, and shows on rsp_tvalid
// once it reaches the last of them. A load takes effect for the very next
// transform request.
//
// Reset empties the pipeline and sets the matrix to identity. While the
// receiver holds rsp_tready low the stages fill in turn; req_tready drops
// only once all four hold an item, and nothing is lost or repeated.
module matrix_vector_transform_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // entry_index[3:0], entry_value[35:4], vec_x[67:36], vec_y[99:68],
   // vec_z[131:100], vec_w[163:132], zero fill [167:164]
   input  logic [167:0] req_tdata,
   // kind[0]
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
   output logic [127:0] rsp_tdata,
   // saturated[0]
   output logic [0:0]   rsp_tuser
);

   mvt_pkg::vec_field_type  vec;
   mvt_pkg::vec_field_type  words;
   mvt_pkg::prod_array_type prod;
   mvt_pkg::sum_array_type  sum;
   logic                    prod_valid;
   logic                    prod_ready;
   logic                    sum_valid;
   logic                    sum_ready;
   mvt_pkg::kind_type       kind;

   // Unpack the request
   assign kind   = mvt_pkg::kind_type'(req_tuser[0]);
   assign vec[0] = req_tdata[67:36];
   assign vec[1] = req_tdata[99:68];
   assign vec[2] = req_tdata[131:100];
   assign vec[3] = req_tdata[163:132];

   mvt_mul_stage u_mul (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_kind     (kind),
      .entry_index (req_tdata[3:0]),
      .entry_value (req_tdata[35:4]),
      .vec         (vec),
      .out_valid   (prod_valid),
      .out_ready   (prod_ready),
      .out_prod    (prod)
   );

   mvt_add_stage u_add (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_prod   (prod),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_sum   (sum)
   );

   mvt_sat_stage u_sat (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (sum_valid),
      .in_ready      (sum_ready),
      .in_sum        (sum),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_words     (words),
      .out_saturated (rsp_tuser[0])
   );

   // Pack the result
   assign rsp_tdata = {words[3], words[2], words[1], words[0]};

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench of the 4x4 matrix by vector transform core.
module testbench;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int PHASE_REQUESTS = 360;
   localparam int FLUSH_CYCLES   = 20;
   localparam int SHOWN_ERRORS   = 10;

   // Four result components and the clip flag, as the core reports them
   typedef struct packed {
      logic                   sat;
      mvt_pkg::vec_field_type comp;
   } vertex_out_type;

   // One request of the stimulus, with an optional typed-in result
   typedef struct packed {
      mvt_pkg::kind_type      kind;
      logic [3:0]             index;
      mvt_pkg::field_type     value;
      mvt_pkg::vec_field_type vec;
      bit                     typed;
      vertex_out_type         want;
   } request_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [167:0] req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic [0:0]   rsp_tuser;

   mvt_pkg::word_type coeffs [mvt_pkg::ENTRIES];
   request_row_type   directed_rows [$];
   request_row_type   pending_rows [$];
   vertex_out_type    vertex_q [$];
   int                mismatches = 0;
   int                cycle_count = 0;
   int                stall_pct = 0;
   string             axis_names [mvt_pkg::DIM] = '{"out_x", "out_y", "out_z", "out_w"};

   matrix_vector_transform_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Row dot products, floored shift, clip to a signed word
   function automatic vertex_out_type transform_vertex(mvt_pkg::vec_field_type v);
      vertex_out_type      r;
      logic signed [66:0]  acc;
      logic signed [66:0]  hi_lim;
      logic signed [66:0]  lo_lim;
      logic signed [63:0]  prod;
      hi_lim = (67'sd1 <<< (mvt_pkg::WORD_BITS - 1)) - 67'sd1;
      lo_lim = -(67'sd1 <<< (mvt_pkg::WORD_BITS - 1));
      r = '0;
      for (int row = 0; row < mvt_pkg::DIM; row++) begin
         acc = '0;
         for (int col = 0; col < mvt_pkg::DIM; col++) begin
            prod = coeffs[row*mvt_pkg::DIM + col]
                   * $signed(v[col][mvt_pkg::WORD_BITS-1:0]);
            acc  = acc + prod;
         end
         acc = acc >>> mvt_pkg::FRAC_BITS;
         if (acc > hi_lim) begin
            r.comp[row] = hi_lim[mvt_pkg::FIELD_BITS-1:0];
            r.sat       = 1'b1;
         end else if (acc < lo_lim) begin
            r.comp[row] = lo_lim[mvt_pkg::FIELD_BITS-1:0];
            r.sat       = 1'b1;
         end else begin
            r.comp[row] = acc[mvt_pkg::FIELD_BITS-1:0];
         end
      end
      return r;
   endfunction

   task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      if (mismatches < SHOWN_ERRORS)
         $display("mismatch %s: expected %h, got %h", what, want, got);
      mismatches++;
   endtask

   // Track accepted requests: update the matrix copy, queue the expected result
   always @(posedge clock) begin
      request_row_type row;
      if (reset) begin
         for (int i = 0; i < mvt_pkg::ENTRIES; i++)
            coeffs[i] = (i % (mvt_pkg::DIM + 1) == 0)
                        ? mvt_pkg::word_type'(64'd1 << mvt_pkg::FRAC_BITS) : '0;
      end else if (req_tvalid && req_tready) begin
         row = pending_rows.pop_front();
         if (row.kind == mvt_pkg::KIND_LOAD) begin
            coeffs[row.index] = mvt_pkg::word_type'(row.value[mvt_pkg::WORD_BITS-1:0]);
         end else if (row.typed) begin
            vertex_q.push_back(row.want);
         end else begin
            vertex_q.push_back(transform_vertex(row.vec));
         end
      end
   end

   // Receiver: stall at random, compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      vertex_out_type want;
      vertex_out_type got;
      rsp_tready <= ($urandom_range(99) >= stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.sat  = rsp_tuser[0];
         got.comp = mvt_pkg::vec_field_type'(rsp_tdata);
         if (vertex_q.size() == 0) begin
            note_mismatch("unexpected result", '0, got.comp[0]);
         end else begin
            want = vertex_q.pop_front();
            for (int c = 0; c < mvt_pkg::DIM; c++)
               if (got.comp[c] !== want.comp[c])
                  note_mismatch(axis_names[c], want.comp[c], got.comp[c]);
            if (got.sat !== want.sat)
               note_mismatch("saturated", 32'(want.sat), 32'(got.sat));
         end
      end
   end

   function automatic mvt_pkg::vec_field_type vec4(mvt_pkg::field_type x,
                                                   mvt_pkg::field_type y,
                                                   mvt_pkg::field_type z,
                                                   mvt_pkg::field_type w);
      return {w, z, y, x};
   endfunction

   task automatic add_row(mvt_pkg::kind_type kind, logic [3:0] index,
                          mvt_pkg::field_type value, mvt_pkg::vec_field_type vec,
                          bit typed, vertex_out_type want);
      request_row_type r;
      r.kind  = kind;
      r.index = index;
      r.value = value;
      r.vec   = vec;
      r.typed = typed;
      r.want  = want;
      directed_rows.push_back(r);
   endtask

   // Mostly modest values, with extremes and fully random words mixed in
   function automatic mvt_pkg::field_type random_word();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return $urandom();
         4: return ($urandom_range(0, 1) != 0) ? 32'h0000_0001 : 32'hFFFF_FFFF;
         default: return mvt_pkg::field_type'($urandom_range(0, 32'h0010_0000))
                         - 32'h0008_0000;
      endcase
   endfunction

   function automatic request_row_type random_request();
      request_row_type r;
      r.kind  = ($urandom_range(99) < 30) ? mvt_pkg::KIND_LOAD : mvt_pkg::KIND_XFORM;
      r.index = 4'($urandom_range(0, 15));
      r.value = random_word();
      r.vec   = vec4(random_word(), random_word(), random_word(), random_word());
      r.typed = 1'b0;
      r.want  = '0;
      return r;
   endfunction

   // Present one request after a random gap and hold it until taken
   task automatic present_request(request_row_type r, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      pending_rows.push_back(r);
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tdata  <= {4'b0000, r.vec, r.value, r.index};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   // Hold the sender off until every expected result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_rows.size() != 0 || vertex_q.size() != 0)
         @(posedge clock);
   endtask

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      int sender_idle [4] = '{0, 61, 0, 32};
      int recv_stall  [4] = '{0, 0, 61, 32};
      vertex_out_type w;

      // Identity after reset passes the vector through
      w.sat  = 1'b0;
      w.comp = vec4(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, 32'h1234_5678);
      add_row(mvt_pkg::KIND_XFORM, 4'hF, 32'hFFFF_FFFF, w.comp, 1'b1, w);
      w.comp = vec4(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
      add_row(mvt_pkg::KIND_XFORM, 4'h0, 32'h0, w.comp, 1'b1, w);
      // Largest entry times largest component clips high; vector of a load is ignored
      add_row(mvt_pkg::KIND_LOAD, 4'h0, 32'h7FFF_FFFF, {4{32'hFFFF_FFFF}}, 1'b0, '0);
      w.sat  = 1'b1;
      w.comp = vec4(32'h7FFF_FFFF, 32'h1, 32'h2, 32'h3);
      add_row(mvt_pkg::KIND_XFORM, 4'h0, 32'h0, vec4(32'h7FFF_FFFF, 32'h1, 32'h2, 32'h3),
              1'b1, w);
      // Smallest entry times largest component clips low
      add_row(mvt_pkg::KIND_LOAD, 4'h0, 32'h8000_0000, '0, 1'b0, '0);
      w.comp = vec4(32'h8000_0000, 32'h0, 32'h0, 32'h0);
      add_row(mvt_pkg::KIND_XFORM, 4'h0, 32'h0, vec4(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0),
              1'b1, w);
      // Shift floors toward minus infinity
      add_row(mvt_pkg::KIND_LOAD, 4'h0, 32'h0000_0001, '0, 1'b0, '0);
      add_row(mvt_pkg::KIND_XFORM, 4'h3, 32'h5, vec4(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0),
              1'b0, '0);
      add_row(mvt_pkg::KIND_XFORM, 4'h0, 32'h0,
              vec4(32'h0000_0001, 32'h1, 32'hFFFF_FFFF, 32'h0), 1'b0, '0);
      // A row of smallest entries against a vector of smallest components
      for (int i = 4; i < 8; i++)
         add_row(mvt_pkg::KIND_LOAD, 4'(i), 32'h8000_0000, '0, 1'b0, '0);
      add_row(mvt_pkg::KIND_XFORM, 4'h0, 32'h0, {4{32'h8000_0000}}, 1'b0, '0);
      add_row(mvt_pkg::KIND_LOAD, 4'hF, 32'h7FFF_FFFF, '0, 1'b0, '0);
      add_row(mvt_pkg::KIND_LOAD, 4'hA, 32'hFFFF_FFFF, '0, 1'b0, '0);
      add_row(mvt_pkg::KIND_XFORM, 4'hF, 32'h0, vec4(32'h0003_8000, 32'hFFFE_4000,
              32'h7FFF_FFFF, 32'h8000_0000), 1'b0, '0);
      add_row(mvt_pkg::KIND_XFORM, 4'hA, 32'h1234_5678, {4{32'hFFFF_FFFF}}, 1'b0, '0);

      // Hold reset, then release it
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int phase = 0; phase < 4; phase++) begin
         stall_pct = recv_stall[phase];
         if (phase == 0)
            foreach (directed_rows[i])
               present_request(directed_rows[i], sender_idle[phase]);
         for (int n = 0; n < PHASE_REQUESTS; n++)
            present_request(random_request(), sender_idle[phase]);
         drain_results();
      end

      // Let anything stray come out before the final verdict
      repeat (FLUSH_CYCLES) @(posedge clock);
      if (vertex_q.size() != 0)
         note_mismatch("results missing", 32'(vertex_q.size()), '0);

      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+sv
sv/mvt_pkg.sv
sv/mvt_mul_stage.sv
sv/mvt_add_stage.sv
sv/mvt_sat_stage.sv
sv/matrix_vector_transform_core.sv
tb/sv/testbench.sv
